// File: rtl/lots_pkg.sv
package lots_pkg;

	localparam int KEY_W = 32;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_DUMP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	typedef logic signed [KEY_W-1:0] key_t;

	typedef struct packed {
		cmd_t cmd;
		key_t key;
	} req_t;

	typedef struct packed {
		status_t status;
		logic    found;
		key_t    value;
		logic    last;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_RESP = 3'b100
	} state_t;

endpackage

// File: rtl/lots_cell.sv
module lots_cell (
	input  logic           clk,
	input  logic           shift,
	input  logic           wr_en,
	input  lots_pkg::key_t wr_data,
	input  lots_pkg::key_t nxt,
	output lots_pkg::key_t q
);

	lots_pkg::key_t entry_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= wr_data;
		end else if (shift) begin
			entry_q <= nxt;
		end
	end

	assign q = entry_q;

endmodule

// File: rtl/lots_ring.sv
module lots_ring #(
	parameter int CAPACITY = 64,
	parameter int IDX_W    = $clog2(CAPACITY)
) (
	input  logic             clk,
	input  logic             shift,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  lots_pkg::key_t   wr_data,
	output lots_pkg::key_t   head
);

	lots_pkg::key_t cell_q [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam int NXT = (i + 1) % CAPACITY;
		logic cell_we;

		assign cell_we = wr_en && (wr_idx == IDX_W'(i));

		lots_cell u_cell (
			.clk     (clk),
			.shift   (shift),
			.wr_en   (cell_we),
			.wr_data (wr_data),
			.nxt     (cell_q[NXT]),
			.q       (cell_q[i])
		);
	end

	assign head = cell_q[0];

endmodule

// File: rtl/level_order_tree_store.sv
// Channel  Dir  Handshake             Payload
// req      in   req_valid/req_ready   lots_pkg::req_t  {cmd, key}
// rsp      out  rsp_valid/rsp_ready   lots_pkg::rsp_t  {status, found, value, last}
//
// Insert, and any request on an empty tree, skips the scan and answers as soon as
// the rsp register is free. Search and delete rotate the cell ring one slot per
// cycle for a full turn, then answer. Dump also turns it fully, sending each entry.
// Reset clears control registers and fill count; cells stay unknown until written.
// A rsp stall holds the ring only while a dump has an entry waiting to go out.
module level_order_tree_store #(
	parameter int CAPACITY = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  lots_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output lots_pkg::rsp_t  rsp
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	lots_pkg::state_t  state_q;
	lots_pkg::cmd_t    op_q;
	lots_pkg::key_t    key_q;
	lots_pkg::key_t    last_val_q;
	lots_pkg::key_t    head;
	lots_pkg::status_t pend_status_q;
	lots_pkg::rsp_t    rsp_q;
	logic [CNT_W-1:0]  fill_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  hit_q;
	logic [IDX_W-1:0]  wr_idx;
	lots_pkg::key_t    wr_data;
	logic              found_q;
	logic              pend_found_q;
	logic              do_del_q;
	logic              rsp_valid_q;
	logic              accept;
	logic              rsp_free;
	logic              in_range;
	logic              at_last_slot;
	logic              hit_now;
	logic              found_nx;
	logic              is_dump;
	logic              step;
	logic              ins_ok;
	logic              resp_go;
	logic              dump_emit;
	logic              wr_en;

	assign req_ready    = (state_q == lots_pkg::S_IDLE);
	assign accept       = req_valid && req_ready;
	assign rsp_free     = !rsp_valid_q || rsp_ready;
	assign in_range     = CNT_W'(idx_q) < fill_q;
	assign at_last_slot = CNT_W'(idx_q) == (fill_q - CNT_ONE);
	assign hit_now      = in_range && (head == key_q);
	assign found_nx     = found_q || hit_now;
	assign is_dump      = (op_q == lots_pkg::CMD_DUMP);
	assign step         = (state_q == lots_pkg::S_SCAN) && (!(is_dump && in_range) || rsp_free);
	assign dump_emit    = step && is_dump && in_range;
	assign resp_go      = (state_q == lots_pkg::S_RESP) && rsp_free;
	assign ins_ok       = accept && (req.cmd == lots_pkg::CMD_INSERT) && (fill_q < CNT_FULL);
	assign wr_en        = ins_ok || (resp_go && do_del_q);
	assign wr_idx       = resp_go ? hit_q : fill_q[IDX_W-1:0];
	assign wr_data      = resp_go ? last_val_q : req.key;

	lots_ring #(
		.CAPACITY (CAPACITY),
		.IDX_W    (IDX_W)
	) u_ring (
		.clk     (clk),
		.shift   (step),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.head    (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lots_pkg::S_IDLE;
			fill_q      <= '0;
			idx_q       <= '0;
			do_del_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				lots_pkg::S_IDLE: begin
					if (accept) begin
						idx_q    <= '0;
						do_del_q <= 1'b0;
						if (req.cmd == lots_pkg::CMD_INSERT) begin
							state_q <= lots_pkg::S_RESP;
							if (ins_ok) begin
								fill_q <= fill_q + CNT_ONE;
							end
						end else if (fill_q == '0) begin
							state_q <= lots_pkg::S_RESP;
						end else begin
							state_q <= lots_pkg::S_SCAN;
						end
					end
				end
				lots_pkg::S_SCAN: begin
					if (step) begin
						idx_q <= idx_q + IDX_W'(1);
						if (idx_q == IDX_LAST) begin
							idx_q <= '0;
							if (is_dump) begin
								state_q <= lots_pkg::S_IDLE;
							end else begin
								state_q  <= lots_pkg::S_RESP;
								do_del_q <= (op_q == lots_pkg::CMD_DELETE) && found_nx;
							end
						end
					end
					if (dump_emit) begin
						rsp_valid_q <= 1'b1;
					end
				end
				lots_pkg::S_RESP: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= lots_pkg::S_IDLE;
						if (do_del_q) begin
							fill_q <= fill_q - CNT_ONE;
						end
					end
				end
				default: begin
					state_q <= lots_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.cmd;
			key_q   <= req.key;
			found_q <= 1'b0;
			pend_found_q <= 1'b0;
			if (req.cmd == lots_pkg::CMD_INSERT) begin
				pend_status_q <= ins_ok ? lots_pkg::STAT_DONE : lots_pkg::STAT_FULL;
			end else begin
				pend_status_q <= lots_pkg::STAT_EMPTY;
			end
		end
		if (step) begin
			found_q <= found_nx;
			if (hit_now) begin
				hit_q <= idx_q;
			end
			if (in_range && at_last_slot) begin
				last_val_q <= head;
			end
			if (idx_q == IDX_LAST) begin
				pend_status_q <= found_nx ? lots_pkg::STAT_DONE : lots_pkg::STAT_NOT_FOUND;
				pend_found_q  <= (op_q == lots_pkg::CMD_SEARCH) && found_nx;
			end
		end
		if (dump_emit) begin
			rsp_q.status <= lots_pkg::STAT_DONE;
			rsp_q.found  <= 1'b0;
			rsp_q.value  <= head;
			rsp_q.last   <= at_last_slot;
		end else if (resp_go) begin
			rsp_q.status <= pend_status_q;
			rsp_q.found  <= pend_found_q;
			rsp_q.value  <= '0;
			rsp_q.last   <= 1'b1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/lots_chk.sv
module lots_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input lots_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input lots_pkg::rsp_t rsp
);

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request dropped or changed while waiting");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp dropped or changed while stalled");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while one is in progress");

	a_fail_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != lots_pkg::STAT_DONE) |-> rsp.last && (rsp.value == '0))
		else $error("failing rsp not single or carries a value");

	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found |-> (rsp.status == lots_pkg::STAT_DONE) && rsp.last)
		else $error("found set on a rsp that is not a completed search");

endmodule

bind level_order_tree_store lots_chk u_lots_chk (.*);

// File: verif/level_order_tree_store_tb.sv
module level_order_tree_store_tb;

	localparam int CAPACITY = 64;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYCLES = 2 * CAPACITY + 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	lots_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	lots_pkg::rsp_t rsp;

	lots_pkg::req_t pending[$];
	lots_pkg::rsp_t answers_due[$];

	lots_pkg::key_t slot_copy[CAPACITY];
	int slot_count = 0;
	int peak_count = 0;

	lots_pkg::key_t key_pool[8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
		32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_00FF};

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	int cycle_count = 0;
	int errors = 0;
	int requests_taken = 0;
	int answers_checked = 0;
	int full_drops = 0;
	int dumps_taken = 0;

	level_order_tree_store #(.CAPACITY(CAPACITY)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void tree_apply(input lots_pkg::req_t r);
		lots_pkg::rsp_t a;
		int hit;
		a.status = lots_pkg::STAT_DONE;
		a.found = 1'b0;
		a.value = '0;
		a.last = 1'b1;
		hit = -1;
		for (int i = 0; i < slot_count; i++)
			if (slot_copy[i] == r.key)
				hit = i;
		case (r.cmd)
		lots_pkg::CMD_INSERT: begin
			if (slot_count == CAPACITY) begin
				a.status = lots_pkg::STAT_FULL;
				full_drops++;
			end else begin
				slot_copy[slot_count] = r.key;
				slot_count++;
			end
			answers_due.push_back(a);
		end
		lots_pkg::CMD_DELETE, lots_pkg::CMD_SEARCH: begin
			if (slot_count == 0)
				a.status = lots_pkg::STAT_EMPTY;
			else if (hit < 0)
				a.status = lots_pkg::STAT_NOT_FOUND;
			else if (r.cmd == lots_pkg::CMD_SEARCH)
				a.found = 1'b1;
			else begin
				slot_copy[hit] = slot_copy[slot_count - 1];
				slot_count--;
			end
			answers_due.push_back(a);
		end
		default: begin
			dumps_taken++;
			if (slot_count == 0) begin
				a.status = lots_pkg::STAT_EMPTY;
				answers_due.push_back(a);
			end else begin
				for (int i = 0; i < slot_count; i++) begin
					a.value = slot_copy[i];
					a.last = (i == slot_count - 1);
					answers_due.push_back(a);
				end
			end
		end
		endcase
		if (slot_count > peak_count)
			peak_count = slot_count;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				tree_apply(req);
				requests_taken++;
			end
			if (!req_valid || req_ready) begin
				if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req <= pending.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_cycles != 0)
			hold_cycles <= hold_cycles - 1;
	end

	always @(posedge clk) begin
		lots_pkg::rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (answers_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected answer, expected none, actual %p", $time, rsp);
				end else begin
					want = answers_due.pop_front();
					answers_checked++;
					if (rsp.status !== want.status) begin
						errors++;
						$display("%0t: status expected %s actual %0d", $time,
							want.status.name(), rsp.status);
					end
					if (rsp.found !== want.found) begin
						errors++;
						$display("%0t: found expected %0b actual %0b", $time,
							want.found, rsp.found);
					end
					if (rsp.value !== want.value) begin
						errors++;
						$display("%0t: value expected %h actual %h", $time,
							want.value, rsp.value);
					end
					if (rsp.last !== want.last) begin
						errors++;
						$display("%0t: last expected %0b actual %0b", $time,
							want.last, rsp.last);
					end
				end
			end
			rsp_ready <= (hold_cycles == 0) && ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d answers outstanding", $time, answers_due.size());
			$display("Verification failed");
			$finish;
		end
	end

	function automatic void queue_req(input lots_pkg::cmd_t c, input lots_pkg::key_t k);
		lots_pkg::req_t r;
		r.cmd = c;
		r.key = k;
		pending.push_back(r);
	endfunction

	function automatic lots_pkg::key_t pick_key();
		if ($urandom_range(99) < 60)
			return key_pool[$urandom_range(7)];
		return $urandom;
	endfunction

	function automatic void queue_random(input int count, input bit shrink);
		int roll;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < (shrink ? 10 : 40))
				queue_req(lots_pkg::CMD_INSERT, pick_key());
			else if (roll < (shrink ? 65 : 60))
				queue_req(lots_pkg::CMD_DELETE, pick_key());
			else if (roll < (shrink ? 85 : 82))
				queue_req(lots_pkg::CMD_SEARCH, pick_key());
			else
				queue_req(lots_pkg::CMD_DUMP, $urandom);
		end
	endfunction

	task automatic drain();
		do
			@(negedge clk);
		while (pending.size() != 0 || req_valid || answers_due.size() != 0);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		queue_req(lots_pkg::CMD_SEARCH, 32'h0000_0005);
		queue_req(lots_pkg::CMD_DELETE, 32'h0000_0005);
		queue_req(lots_pkg::CMD_DUMP, 32'h0000_0000);
		queue_req(lots_pkg::CMD_INSERT, 32'h8000_0000);
		queue_req(lots_pkg::CMD_INSERT, 32'h7FFF_FFFF);
		queue_req(lots_pkg::CMD_INSERT, 32'h0000_0000);
		queue_req(lots_pkg::CMD_INSERT, 32'hFFFF_FFFF);
		queue_req(lots_pkg::CMD_INSERT, 32'h7FFF_FFFF);
		queue_req(lots_pkg::CMD_INSERT, 32'h5555_5555);
		queue_req(lots_pkg::CMD_INSERT, 32'hAAAA_AAAA);
		queue_req(lots_pkg::CMD_DUMP, 32'hFFFF_FFFF);
		queue_req(lots_pkg::CMD_SEARCH, 32'h7FFF_FFFF);
		queue_req(lots_pkg::CMD_SEARCH, 32'h0000_1234);
		queue_req(lots_pkg::CMD_SEARCH, 32'h8000_0000);
		queue_req(lots_pkg::CMD_DELETE, 32'h7FFF_FFFF);
		queue_req(lots_pkg::CMD_DELETE, 32'hAAAA_AAAA);
		queue_req(lots_pkg::CMD_DELETE, 32'h5555_5555);
		queue_req(lots_pkg::CMD_DELETE, 32'h0000_1234);
		queue_req(lots_pkg::CMD_DUMP, 32'h0000_0000);
		queue_req(lots_pkg::CMD_DELETE, 32'h8000_0000);
		queue_req(lots_pkg::CMD_SEARCH, 32'h8000_0000);
		queue_req(lots_pkg::CMD_DUMP, 32'h0000_0000);
		drain();

		send_idle_pct = 75;
		for (int n = slot_count; n < CAPACITY + 3; n++)
			queue_req(lots_pkg::CMD_INSERT, pick_key());
		queue_req(lots_pkg::CMD_DUMP, $urandom);
		queue_random(15, 1'b0);
		drain();

		send_idle_pct = 0;
		stall_pct = 75;
		queue_random(25, 1'b1);
		drain();

		send_idle_pct = 31;
		stall_pct = 31;
		queue_random(25, 1'b0);
		drain();

		send_idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 300;
		queue_req(lots_pkg::CMD_DUMP, $urandom);
		queue_random(10, 1'b0);
		drain();

		queue_random(20, 1'b1);
		drain();

		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Covered %0d requests (%0d dumps, %0d inserts refused on a full tree),",
			requests_taken, dumps_taken, full_drops);
		$display("%0d answers checked, tree held up to %0d entries", answers_checked,
			peak_count);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
